[hdl/abpo_pkg.sv]
package abpo_pkg;

    // Lane width of one Q8.8 coordinate
    localparam int COORD_WIDTH = 16;
    localparam int AXES        = 3;
    localparam int VEC_W       = AXES * COORD_WIDTH;
    localparam int MOVE_W      = COORD_WIDTH + 1;
    localparam int NORM_W      = 2;
    // |ca - cb| - (ha + hb) spans CW+2 bits signed; one spare bit for negation
    localparam int CHECK_W     = COORD_WIDTH + 3;

    // Stream word layout
    localparam int S_FIELDS_W  = 4 * VEC_W;
    localparam int S_DATA_W    = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_USER_W    = 4;
    localparam int M_FIELDS_W  = 2 * AXES * MOVE_W + AXES * NORM_W;
    localparam int M_DATA_W    = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_USER_W    = 2;

    // Input flag positions in tuser
    localparam int U_TRIG_A    = 0;
    localparam int U_TRIG_B    = 1;
    localparam int U_STAT_A    = 2;
    localparam int U_STAT_B    = 3;

    // Sign codes of a normal lane
    localparam logic signed [NORM_W-1:0] NORM_POS  = 2'sd1;
    localparam logic signed [NORM_W-1:0] NORM_NEG  = -2'sd1;
    localparam logic signed [NORM_W-1:0] NORM_ZERO = 2'sd0;

    // Largest correction magnitude
    localparam logic signed [CHECK_W-1:0] MOVE_LIM =
        CHECK_W'((64'd1 << COORD_WIDTH) - 64'd1);

    typedef logic signed [CHECK_W-1:0] check_t;
    typedef logic signed [MOVE_W-1:0]  move_t;
    typedef logic signed [NORM_W-1:0]  norm_t;

    // Per-axis separation result
    typedef struct packed {
        check_t check;
        norm_t  norm;
    } axis_res_t;

    // Saturate a correction to the move field range
    function automatic move_t clamp_move(input check_t v);
        move_t r;
        if (v > MOVE_LIM)
            r = MOVE_W'(MOVE_LIM);
        else if (v < -MOVE_LIM)
            r = MOVE_W'(-MOVE_LIM);
        else
            r = MOVE_W'(v);
        return r;
    endfunction

endpackage

[hdl/abpo_axis.sv]
module abpo_axis
    import abpo_pkg::*;
(
    input  logic [COORD_WIDTH-1:0] center_a,
    input  logic [COORD_WIDTH-1:0] half_a,
    input  logic [COORD_WIDTH-1:0] center_b,
    input  logic [COORD_WIDTH-1:0] half_b,
    output axis_res_t              res
);

    check_t delta;
    check_t abs_delta;
    check_t reach;

    // Signed center distance, extended to the check width
    always_comb
    begin
        delta     = CHECK_W'(signed'(center_a)) - CHECK_W'(signed'(center_b));
        abs_delta = delta[CHECK_W-1] ? -delta : delta;
        reach     = check_t'(CHECK_W'(half_a)) + check_t'(CHECK_W'(half_b));
    end

    // Separation along the axis and sign of A relative to B
    always_comb
    begin
        res.check = abs_delta - reach;
        if (delta[CHECK_W-1])
            res.norm = NORM_NEG;
        else if (delta != '0)
            res.norm = NORM_POS;
        else
            res.norm = NORM_ZERO;
    end

endmodule

[hdl/abpo_resolve.sv]
module abpo_resolve
    import abpo_pkg::*;
(
    input  axis_res_t axis_res [AXES],
    input  logic      trigger_a,
    input  logic      trigger_b,
    input  logic      static_a,
    input  logic      static_b,
    output logic      hit,
    output logic      resolved,
    output move_t     move_a [AXES],
    output move_t     move_b [AXES],
    output norm_t     normal [AXES]
);

    check_t most;
    check_t adjust [AXES];
    check_t half_adj [AXES];

    // Overlap test and least-penetration search
    always_comb
    begin
        hit = 1'b1;
        for (int i = 0; i < AXES; i++)
        begin
            if (!axis_res[i].check[CHECK_W-1])
                hit = 1'b0;
        end
        resolved = hit && !trigger_a && !trigger_b;
        most = axis_res[0].check;
        for (int i = 1; i < AXES; i++)
        begin
            if (axis_res[i].check > most)
                most = axis_res[i].check;
        end
    end

    // Normals and corrections per axis
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            if (resolved && axis_res[i].check == most)
                normal[i] = axis_res[i].norm;
            else
                normal[i] = NORM_ZERO;

            case (normal[i])
                NORM_POS: adjust[i] = axis_res[i].check;
                NORM_NEG: adjust[i] = -axis_res[i].check;
                default:  adjust[i] = '0;
            endcase
            half_adj[i] = adjust[i] >>> 1;

            move_a[i] = '0;
            move_b[i] = '0;
            if (!static_a && !static_b)
            begin
                move_a[i] = clamp_move(-half_adj[i]);
                move_b[i] = clamp_move(half_adj[i]);
            end
            else if (!static_a)
            begin
                move_a[i] = clamp_move(-adjust[i]);
            end
            else
            begin
                move_b[i] = clamp_move(adjust[i]);
            end
        end
    end

endmodule

[hdl/aabb_pair_overlap_push_out_core.sv]
// Box pair overlap and push-out unit.
// Slave channel (s_*): one word per box pair. tdata carries center_a, half_a,
// center_b, half_b (48 bits each, lanes x/y/z, Q8.8); tuser carries the
// trigger and static flags of both boxes.
// Master channel (m_*): one word per pair. tdata carries the six Q9.8
// corrections (17-bit signed) and the three sign normals; tuser carries
// hit and resolved.
// Datapath: input register, then result register, with the overlap and
// push-out logic between them.
// Throughput: one pair per cycle; both register stages advance together
// whenever the result register is empty or being drained.
// Stall: when m_tready is low the result word holds, the input stage holds
// its pair, and s_tready drops only once both stages are full.
// Reset: both stages are emptied; s_tready is high right after reset.
module aabb_pair_overlap_push_out_core
    import abpo_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // center_a, half_a, center_b, half_b
    input  logic [S_DATA_W-1:0] s_tdata,
    // trigger_a, trigger_b, static_a, static_b
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // move_a_x/y/z, move_b_x/y/z, normal_x/y/z, zero pad
    output logic [M_DATA_W-1:0] m_tdata,
    // hit, resolved
    output logic [M_USER_W-1:0] m_tuser
);

    logic                  in_valid_reg;
    logic [S_FIELDS_W-1:0] in_data_reg;
    logic [S_USER_W-1:0]   in_user_reg;
    logic                  out_valid_reg;
    logic [M_DATA_W-1:0]   out_data_reg;
    logic [M_USER_W-1:0]   out_user_reg;
    logic                  out_load;
    logic                  in_load;

    logic [VEC_W-1:0]      center_a;
    logic [VEC_W-1:0]      half_a;
    logic [VEC_W-1:0]      center_b;
    logic [VEC_W-1:0]      half_b;
    axis_res_t             axis_res [AXES];
    logic                  hit;
    logic                  resolved;
    move_t                 move_a [AXES];
    move_t                 move_b [AXES];
    norm_t                 normal [AXES];
    logic [M_DATA_W-1:0]   out_data_next;

    // Handshake: stages move together whenever the result word can be replaced
    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_load)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Input word register
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_data_reg <= s_tdata[S_FIELDS_W-1:0];
            in_user_reg <= s_tuser;
        end
    end

    // Field unpacking
    assign center_a = in_data_reg[0*VEC_W +: VEC_W];
    assign half_a   = in_data_reg[1*VEC_W +: VEC_W];
    assign center_b = in_data_reg[2*VEC_W +: VEC_W];
    assign half_b   = in_data_reg[3*VEC_W +: VEC_W];

    // Per-axis separation
    for (genvar g = 0; g < AXES; g++)
    begin : g_axis
        abpo_axis u_axis
        (
            .center_a (center_a[g*COORD_WIDTH +: COORD_WIDTH]),
            .half_a   (half_a[g*COORD_WIDTH +: COORD_WIDTH]),
            .center_b (center_b[g*COORD_WIDTH +: COORD_WIDTH]),
            .half_b   (half_b[g*COORD_WIDTH +: COORD_WIDTH]),
            .res      (axis_res[g])
        );
    end

    abpo_resolve u_resolve
    (
        .axis_res  (axis_res),
        .trigger_a (in_user_reg[U_TRIG_A]),
        .trigger_b (in_user_reg[U_TRIG_B]),
        .static_a  (in_user_reg[U_STAT_A]),
        .static_b  (in_user_reg[U_STAT_B]),
        .hit       (hit),
        .resolved  (resolved),
        .move_a    (move_a),
        .move_b    (move_b),
        .normal    (normal)
    );

    // Result word packing
    always_comb
    begin
        out_data_next = '0;
        for (int i = 0; i < AXES; i++)
        begin
            out_data_next[i*MOVE_W +: MOVE_W]          = move_a[i];
            out_data_next[(AXES+i)*MOVE_W +: MOVE_W]   = move_b[i];
            out_data_next[2*AXES*MOVE_W + i*NORM_W +: NORM_W] = normal[i];
        end
    end

    // Result word register
    always_ff @(posedge clk)
    begin
        if (out_load && in_valid_reg)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= {resolved, hit};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // A pair in the input stage reaches the output stage on the next edge
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_load |=> out_valid_reg)
        else $error("input stage lost a pair");

    // resolved only together with hit
    a_res_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tuser[1] || m_tuser[0]))
        else $error("resolved without hit");

    // An unresolved pair carries no correction and no normal
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> m_tdata == '0)
        else $error("corrections on unresolved pair");

    // A nonzero x correction needs a kept x axis
    a_norm_x: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[MOVE_W-1:0] != '0
                     || m_tdata[AXES*MOVE_W +: MOVE_W] != '0)
        |-> m_tdata[2*AXES*MOVE_W +: NORM_W] != '0)
        else $error("x correction without x normal");

endmodule

[tb/tb_aabb_pair_overlap_push_out_core.sv]
`timescale 1ns / 100ps

module tb_aabb_pair_overlap_push_out_core;
    import abpo_pkg::*;

    // Result tuser bit positions
    localparam int M_HIT = 0;
    localparam int M_RES = 1;

    // Flag sets for tuser of the input word
    localparam logic [S_USER_W-1:0] FL_NONE = '0;
    localparam logic [S_USER_W-1:0] FL_TA   = S_USER_W'(1 << U_TRIG_A);
    localparam logic [S_USER_W-1:0] FL_TB   = S_USER_W'(1 << U_TRIG_B);
    localparam logic [S_USER_W-1:0] FL_SA   = S_USER_W'(1 << U_STAT_A);
    localparam logic [S_USER_W-1:0] FL_SB   = S_USER_W'(1 << U_STAT_B);

    localparam int RAND_PER_PHASE = 440;
    localparam int LONG_HOLD      = 200;
    localparam int DRAIN_CYCLES   = 10;
    localparam int STALL_LIMIT    = 1000;
    localparam logic [COORD_WIDTH-1:0] H1 = 16'h0100;
    localparam logic [COORD_WIDTH-1:0] HM = 16'hFFFF;

    // One queued entry: a box pair, or a phase mark that waits for the
    // pipe to drain and then sets the idle rates (and maybe a long hold)
    typedef struct packed {
        logic                mark;
        logic                hold;
        logic [6:0]          send_pct;
        logic [6:0]          recv_pct;
        logic [S_USER_W-1:0] flags;
        logic [VEC_W-1:0]    hb;
        logic [VEC_W-1:0]    cb;
        logic [VEC_W-1:0]    ha;
        logic [VEC_W-1:0]    ca;
    } stim_t;

    // Push-out result of one pair
    typedef struct packed {
        logic                          hit;
        logic                          resolved;
        logic [AXES-1:0][MOVE_W-1:0]   mv_a;
        logic [AXES-1:0][MOVE_W-1:0]   mv_b;
        logic [AXES-1:0][NORM_W-1:0]   nrm;
    } push_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [S_USER_W-1:0] s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;

    stim_t pending_q[$];
    push_t push_q[$];
    stim_t offered;

    int   n_accepted = 0;
    int   n_checked = 0;
    int   n_hit = 0;
    int   n_resolved = 0;
    int   errors = 0;
    int   idle_cycles = 0;
    int   hold_asked = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   send_pct = 0;
    int   recv_pct = 0;

    aabb_pair_overlap_push_out_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Saturate a correction to +-(2^CW - 1)
    function automatic logic [MOVE_W-1:0] sat_move(input longint v);
        longint lim;
        lim = (longint'(1) << COORD_WIDTH) - 1;
        if (v > lim)
            return MOVE_W'(lim);
        if (v < -lim)
            return MOVE_W'(-lim);
        return MOVE_W'(v);
    endfunction

    // Overlap test and least-penetration push-out of one pair
    function automatic push_t predict_push(input stim_t p);
        push_t  r;
        longint chk [AXES];
        longint sgn [AXES];
        longint d;
        longint most;
        longint adj;
        longint h;
        r = '0;
        r.hit = 1'b1;
        for (int i = 0; i < AXES; i++)
        begin
            d = longint'($signed(p.ca[i*COORD_WIDTH +: COORD_WIDTH]))
              - longint'($signed(p.cb[i*COORD_WIDTH +: COORD_WIDTH]));
            chk[i] = (d < 0 ? -d : d)
                   - (longint'(p.ha[i*COORD_WIDTH +: COORD_WIDTH])
                      + longint'(p.hb[i*COORD_WIDTH +: COORD_WIDTH]));
            sgn[i] = (d > 0) ? 1 : ((d < 0) ? -1 : 0);
            if (chk[i] >= 0)
                r.hit = 1'b0;
        end
        r.resolved = r.hit && !p.flags[U_TRIG_A] && !p.flags[U_TRIG_B];
        if (r.resolved)
        begin
            most = chk[0];
            if (chk[1] > most)
                most = chk[1];
            if (chk[2] > most)
                most = chk[2];
            for (int i = 0; i < AXES; i++)
            begin
                // only the least penetrated axes push
                if (chk[i] < most)
                    sgn[i] = 0;
                adj = chk[i] * sgn[i];
                r.nrm[i] = (sgn[i] > 0) ? NORM_POS : ((sgn[i] < 0) ? NORM_NEG : NORM_ZERO);
                if (!p.flags[U_STAT_A] && !p.flags[U_STAT_B])
                begin
                    h = adj >>> 1;
                    r.mv_a[i] = sat_move(-h);
                    r.mv_b[i] = sat_move(h);
                end
                else if (!p.flags[U_STAT_A])
                    r.mv_a[i] = sat_move(-adj);
                else
                    r.mv_b[i] = sat_move(adj);
            end
        end
        return r;
    endfunction

    function automatic string fmt_push(input push_t r);
        return $sformatf("hit=%0b res=%0b A=(%0d,%0d,%0d) B=(%0d,%0d,%0d) n=(%0d,%0d,%0d)",
            r.hit, r.resolved,
            $signed(r.mv_a[0]), $signed(r.mv_a[1]), $signed(r.mv_a[2]),
            $signed(r.mv_b[0]), $signed(r.mv_b[1]), $signed(r.mv_b[2]),
            $signed(r.nrm[0]), $signed(r.nrm[1]), $signed(r.nrm[2]));
    endfunction

    function automatic logic [VEC_W-1:0] lanes(input logic [COORD_WIDTH-1:0] x,
                                               input logic [COORD_WIDTH-1:0] y,
                                               input logic [COORD_WIDTH-1:0] z);
        return {z, y, x};
    endfunction

    task automatic add_pair(input logic [VEC_W-1:0] ca, input logic [VEC_W-1:0] ha,
                            input logic [VEC_W-1:0] cb, input logic [VEC_W-1:0] hb,
                            input logic [S_USER_W-1:0] flags);
        stim_t s;
        s = '0;
        s.ca = ca;
        s.ha = ha;
        s.cb = cb;
        s.hb = hb;
        s.flags = flags;
        pending_q.push_back(s);
    endtask

    task automatic add_mark(input int snd, input int rcv, input logic hold);
        stim_t s;
        s = '0;
        s.mark = 1'b1;
        s.hold = hold;
        s.send_pct = 7'(snd);
        s.recv_pct = 7'(rcv);
        pending_q.push_back(s);
    endtask

    // Mostly near or touching boxes so that hits and ties are common;
    // the rest are raw random words
    function automatic stim_t rand_pair();
        stim_t                  s;
        int                     kind;
        int                     ax;
        logic                   same;
        logic [COORD_WIDTH-1:0] base;
        logic [COORD_WIDTH-1:0] ha;
        logic [COORD_WIDTH-1:0] hb;
        logic [COORD_WIDTH-1:0] off;
        s = '0;
        ha = '0;
        hb = '0;
        off = '0;
        kind = $urandom_range(0, 99);
        same = ($urandom_range(0, 3) == 0);
        ax = $urandom_range(0, AXES - 1);
        if (kind < 20)
        begin
            s.ca = VEC_W'({$urandom, $urandom});
            s.ha = VEC_W'({$urandom, $urandom});
            s.cb = VEC_W'({$urandom, $urandom});
            s.hb = VEC_W'({$urandom, $urandom});
        end
        else
        begin
            for (int i = 0; i < AXES; i++)
            begin
                if (i == 0 || !same)
                begin
                    ha = COORD_WIDTH'($urandom_range(0, 1023));
                    hb = COORD_WIDTH'($urandom_range(0, 1023));
                    off = COORD_WIDTH'($urandom_range(0, ha + hb + 4));
                end
                // exact touch or one-unit overlap on one axis
                if (kind < 35 && i == ax)
                    off = ha + hb - COORD_WIDTH'($urandom_range(0, 1));
                base = COORD_WIDTH'($urandom);
                s.ca[i*COORD_WIDTH +: COORD_WIDTH] = base;
                s.cb[i*COORD_WIDTH +: COORD_WIDTH] = $urandom_range(0, 1) ? base + off
                                                                          : base - off;
                s.ha[i*COORD_WIDTH +: COORD_WIDTH] = ha;
                s.hb[i*COORD_WIDTH +: COORD_WIDTH] = hb;
            end
        end
        s.flags[U_TRIG_A] = ($urandom_range(0, 9) == 0);
        s.flags[U_TRIG_B] = ($urandom_range(0, 9) == 0);
        s.flags[U_STAT_A] = 1'($urandom_range(0, 1));
        s.flags[U_STAT_B] = 1'($urandom_range(0, 1));
        return s;
    endfunction

    // Input driver: offers queued pairs, handles phase marks
    always @(posedge clk or negedge rst_n)
    begin : pair_driver
        stim_t nxt;
        logic  give;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                push_q.push_back(predict_push(offered));
                n_accepted <= n_accepted + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                give = 1'b0;
                if (pending_q.size() != 0)
                begin
                    nxt = pending_q[0];
                    if (nxt.mark)
                    begin
                        // wait until every result of the phase is back
                        if (!s_tvalid && n_checked == n_accepted)
                        begin
                            pending_q.delete(0);
                            send_pct <= int'(nxt.send_pct);
                            recv_pct <= int'(nxt.recv_pct);
                            if (nxt.hold)
                                hold_asked <= hold_asked + 1;
                        end
                    end
                    else if ($urandom_range(0, 99) >= send_pct)
                    begin
                        pending_q.delete(0);
                        offered = nxt;
                        give = 1'b1;
                        s_tdata <= {nxt.hb, nxt.cb, nxt.ha, nxt.ca};
                        s_tuser <= nxt.flags;
                    end
                end
                s_tvalid <= give;
            end
        end
    end

    // Result side: random stalls plus a long hold on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_seen != hold_asked)
        begin
            hold_seen <= hold_asked;
            hold_left <= LONG_HOLD;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_pct);
    end

    // Result checker
    always @(posedge clk)
    begin : result_check
        push_t got;
        push_t want;
        logic  bad;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.hit = m_tuser[M_HIT];
            got.resolved = m_tuser[M_RES];
            for (int i = 0; i < AXES; i++)
            begin
                got.mv_a[i] = m_tdata[i*MOVE_W +: MOVE_W];
                got.mv_b[i] = m_tdata[(AXES+i)*MOVE_W +: MOVE_W];
                got.nrm[i] = m_tdata[2*AXES*MOVE_W + i*NORM_W +: NORM_W];
            end
            n_checked <= n_checked + 1;
            if (push_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: %s", fmt_push(got));
            end
            else
            begin
                want = push_q.pop_front();
                bad = (got.hit !== want.hit) || (got.resolved !== want.resolved);
                for (int i = 0; i < AXES; i++)
                begin
                    if (got.mv_a[i] !== want.mv_a[i] || got.mv_b[i] !== want.mv_b[i]
                        || got.nrm[i] !== want.nrm[i])
                        bad = 1'b1;
                end
                if (bad)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch on result %0d", n_checked);
                        $display("  expected %s", fmt_push(want));
                        $display("  actual   %s", fmt_push(got));
                    end
                end
                n_hit <= n_hit + int'(want.hit);
                n_resolved <= n_resolved + int'(want.resolved);
            end
        end
    end

    // Watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no word accepted for %0d cycles", idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        // phase 1: busy sender, sparse receiver; directed pairs first
        add_mark(28, 64, 1'b0);
        add_pair('0, '0, '0, '0, FL_NONE);
        add_pair('0, lanes(H1, H1, H1), '0, lanes(H1, H1, H1), FL_NONE);
        add_pair(lanes(16'h0080, '0, '0), lanes(H1, H1, H1), '0, lanes(H1, H1, H1), FL_NONE);
        add_pair(lanes(16'h0080, '0, '0), lanes(H1, H1, H1), '0, lanes(H1, H1, H1), FL_SA);
        add_pair(lanes(16'h0080, '0, '0), lanes(H1, H1, H1), '0, lanes(H1, H1, H1), FL_SB);
        add_pair(lanes(16'h0080, '0, '0), lanes(H1, H1, H1), '0, lanes(H1, H1, H1),
                 FL_SA | FL_SB);
        add_pair(lanes(16'h0080, '0, '0), lanes(H1, H1, H1), '0, lanes(H1, H1, H1), FL_TA);
        add_pair(lanes(16'h0080, '0, '0), lanes(H1, H1, H1), '0, lanes(H1, H1, H1), FL_TB);
        // exact touch, then one unit of overlap
        add_pair(lanes(16'h0200, '0, '0), lanes(H1, H1, H1), '0, lanes(H1, H1, H1), FL_NONE);
        add_pair(lanes(16'h01FF, '0, '0), lanes(H1, H1, H1), '0, lanes(H1, H1, H1), FL_NONE);
        // negative direction and odd corrections that round on halving
        add_pair(lanes(16'hFF81, '0, '0), lanes(H1, H1, H1), '0, lanes(H1, H1, H1), FL_NONE);
        add_pair(lanes(16'h0081, '0, '0), lanes(H1, H1, H1), '0, lanes(H1, H1, H1), FL_NONE);
        // ties on two and on three axes
        add_pair(lanes(16'h0040, 16'hFFC0, '0), lanes(H1, H1, H1), '0, lanes(H1, H1, H1),
                 FL_NONE);
        add_pair(lanes(16'h0040, 16'h0040, 16'hFFC0), lanes(H1, H1, H1), '0,
                 lanes(H1, H1, H1), FL_SB);
        // extreme centers and extents
        add_pair(lanes(16'h7FFF, 16'h7FFF, 16'h7FFF), lanes(HM, HM, HM),
                 lanes(16'h8000, 16'h8000, 16'h8000), lanes(HM, HM, HM), FL_NONE);
        add_pair(lanes(16'h7FFF, 16'h7FFF, 16'h7FFF), lanes(HM, HM, HM),
                 lanes(16'h8000, 16'h8000, 16'h8000), lanes(HM, HM, HM), FL_SA);
        add_pair('0, lanes(HM, HM, HM), '0, lanes(HM, HM, HM), FL_NONE);
        // corrections past the move range saturate
        add_pair(lanes(16'h0001, '0, '0), lanes(HM, HM, HM), '0, lanes(HM, HM, HM), FL_SA);
        add_pair(lanes(16'h0001, '0, '0), lanes(HM, HM, HM), '0, lanes(HM, HM, HM), FL_SB);
        add_pair(lanes(16'h0001, '0, '0), lanes(HM, HM, HM), '0, lanes(HM, HM, HM), FL_NONE);
        add_pair('1, '1, '1, '1, '1);
        add_pair(lanes('0, '0, 16'h4000), lanes(H1, H1, H1), '0, lanes(H1, H1, H1), FL_NONE);
        add_pair(lanes(16'h8000, '0, '0), lanes(16'h8000, 16'h8000, 16'h8000),
                 lanes(16'h7FFF, '0, '0), lanes(16'h8000, 16'h8000, 16'h8000), FL_SB);
        for (int i = 0; i < RAND_PER_PHASE; i++)
            pending_q.push_back(rand_pair());
        // phase 2: sparse sender, busy receiver
        add_mark(64, 28, 1'b0);
        for (int i = 0; i < RAND_PER_PHASE; i++)
            pending_q.push_back(rand_pair());
        // phase 3: no idling, opens with a long result-side hold
        add_mark(0, 0, 1'b1);
        for (int i = 0; i < RAND_PER_PHASE; i++)
            pending_q.push_back(rand_pair());

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_q.size() != 0 || s_tvalid || n_checked != n_accepted);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (push_q.size() != 0)
        begin
            $display("%0d expected results never arrived", push_q.size());
            errors += push_q.size();
        end
        $display("Sent %0d box pairs over three idling phases with one long output hold;",
                 n_accepted);
        $display("%0d overlapped, %0d pushed apart, %0d result errors.",
                 n_hit, n_resolved, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
